[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mhloc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maidenhead locator decode package
// Widths, types and the small constant tables of the locator decoder.
// ----------------------------------------------------------------------------
package mhloc_pkg;

    localparam int MAX_PAIRS = 6;
    localparam int CH_W      = 8;
    localparam int POS_W     = 4;
    localparam int PAIR_W    = 3;
    localparam int VAL_W     = 5;
    localparam int SUM_W     = 22;
    localparam int OUT_W     = 21;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;

    localparam logic [OUT_W-1:0] HALF_SPAN = 21'd1036800;

    // place weights in output units, field / square / subsquare / ext pairs
    localparam logic [SUM_W-1:0] W_PAIR0 = 22'd115200;
    localparam logic [SUM_W-1:0] W_PAIR1 = 22'd11520;
    localparam logic [SUM_W-1:0] W_PAIR2 = 22'd480;
    localparam logic [SUM_W-1:0] W_PAIR3 = 22'd48;
    localparam logic [SUM_W-1:0] W_PAIR4 = 22'd2;

    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] v;
    } t_char_val;

    typedef struct packed {
        logic bad;
        t_sum lon_add;
        t_sum lat_add;
    } t_pair_res;

    function automatic logic [VAL_W-1:0] pair_radix(input logic [PAIR_W-1:0] pair);
        logic [VAL_W-1:0] r;
        case (pair)
            3'd0:    r = 5'd18;
            3'd2:    r = 5'd24;
            3'd4:    r = 5'd24;
            default: r = 5'd10;
        endcase
        return r;
    endfunction

    // Digit pairs take 0..9, letter pairs take A.. or a.. up to the radix.
    function automatic t_char_val char_value(input logic [CH_W-1:0] c,
                                             input logic [PAIR_W-1:0] pair);
        t_char_val        res;
        logic [CH_W-1:0]  d;
        logic [VAL_W-1:0] r;
        r = pair_radix(pair);
        if (pair[0]) begin
            d      = c - CH_ZERO;
            res.ok = (c >= CH_ZERO) && (c <= CH_NINE);
        end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
            d      = c - CH_UP_A;
            res.ok = d < CH_W'(r);
        end else begin
            d      = c - CH_LOW_A;
            res.ok = (c >= CH_LOW_A) && (d < CH_W'(r));
        end
        res.v = d[VAL_W-1:0];
        return res;
    endfunction

    // Weighted value of one character; the last pair folds in its half square.
    function automatic t_sum place_value(input logic [VAL_W-1:0] v,
                                         input logic [PAIR_W-1:0] pair);
        t_sum p;
        case (pair)
            3'd0: p = t_sum'(t_sum'(v) * W_PAIR0);
            3'd1: p = t_sum'(t_sum'(v) * W_PAIR1);
            3'd2: p = t_sum'(t_sum'(v) * W_PAIR2);
            3'd3: p = t_sum'(t_sum'(v) * W_PAIR3);
            3'd4: p = t_sum'(t_sum'(v) * W_PAIR4);
            3'd5: begin
                if (v < 5'd2) begin
                    p = t_sum'(0);
                end else if (v < 5'd7) begin
                    p = t_sum'(1);
                end else begin
                    p = t_sum'(2);
                end
            end
            default: p = t_sum'(0);
        endcase
        return p;
    endfunction

    // Half the square size for the pair count, moved to the -180/-90 origin.
    function automatic logic [OUT_W-1:0] center_offset(input logic [PAIR_W-1:0] pairs);
        logic [OUT_W-1:0] half;
        case (pairs)
            3'd1:    half = 21'd57600;
            3'd2:    half = 21'd5760;
            3'd3:    half = 21'd240;
            3'd4:    half = 21'd24;
            3'd5:    half = 21'd1;
            default: half = 21'd0;
        endcase
        return half - HALF_SPAN;
    endfunction

endpackage

[sv/mhloc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Locator decoder channels
// Valid/ready channels for the character stream and the decoded position.
// ----------------------------------------------------------------------------
interface mhloc_in_if;
    logic                         valid;
    logic                         ready;
    logic [mhloc_pkg::CH_W-1:0]   ch;
    logic                         last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface mhloc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mhloc_pkg::OUT_W-1:0] longitude;
    logic signed [mhloc_pkg::OUT_W-1:0] latitude;
    logic                              valid_res;

    modport source (output valid, output longitude, output latitude, output valid_res,
                    input ready);
    modport sink   (input valid, input longitude, input latitude, input valid_res,
                    output ready);
endinterface

[sv/mhloc_pair_value.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Locator pair value
// Checks both characters of a pair and weights them by the pair's place.
// ----------------------------------------------------------------------------
module mhloc_pair_value (
    input  logic [mhloc_pkg::CH_W-1:0]   i_lon_ch,
    input  logic [mhloc_pkg::CH_W-1:0]   i_lat_ch,
    input  logic [mhloc_pkg::PAIR_W-1:0] i_pair,
    output mhloc_pkg::t_pair_res         o_res
);
    import mhloc_pkg::*;

    t_char_val lon_val;
    t_char_val lat_val;

    always_comb begin
        lon_val       = char_value(i_lon_ch, i_pair);
        lat_val       = char_value(i_lat_ch, i_pair);
        o_res.bad     = !(lon_val.ok && lat_val.ok);
        o_res.lon_add = place_value(lon_val.v, i_pair);
        o_res.lat_add = place_value(lat_val.v, i_pair);
    end

endmodule

[sv/maidenhead_locator_decode_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maidenhead locator decoder
// Decodes a locator, one character per word, to the fixed-point square centre.
// ----------------------------------------------------------------------------
//
//   channel  | dir | word contents
//   ---------+-----+-------------------------------------------------------
//   i_in     | in  | ch (8b ASCII), last (1b end of locator)
//   o_out    | out | longitude (21b s, 1/5760 deg), latitude (21b s,
//            |     | 1/11520 deg), valid_res (1b)
//
// Throughput is one character per cycle while no stalled result holds
// a last character: the pair check, the weighted add into the accumulators
// and the centre offset are combinational between the input and result
// registers; a result loads as its last character leaves the input register.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// accumulators. A stalled result holds the input register only when that
// register carries a last character; other characters keep flowing.
//
`include "assert_macros.svh"

module maidenhead_locator_decode_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhloc_in_if.sink    i_in,
    mhloc_out_if.source o_out
);
    import mhloc_pkg::*;

    // input register
    logic              r_s1_valid;
    logic [CH_W-1:0]   r_s1_ch;
    logic              r_s1_last;

    // locator state
    logic [POS_W-1:0]  r_position;
    logic [CH_W-1:0]   r_held;
    t_sum              r_lon_sum;
    t_sum              r_lat_sum;
    logic              r_bad;

    // result register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_lon;
    logic [OUT_W-1:0]  r_lat;
    logic              r_vres;

    logic [POS_W-1:0]  n_position;
    logic [CH_W-1:0]   n_held;
    t_sum              n_lon_sum;
    t_sum              n_lat_sum;
    logic              n_bad;
    logic [OUT_W-1:0]  n_lon;
    logic [OUT_W-1:0]  n_lat;
    logic              n_vres;

    logic              in_ready;
    logic              s1_go;
    logic              in_window;
    logic [PAIR_W-1:0] pairs;
    t_pair_res         pair_res;

    // Advance the input register unless it holds a last character and the
    // result register is still waiting to be taken.
    assign s1_go    = r_s1_valid && (!r_s1_last || !r_out_valid || o_out.ready);
    assign in_ready = !r_s1_valid || s1_go;

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.longitude = r_lon;
    assign o_out.latitude  = r_lat;
    assign o_out.valid_res = r_vres;

    // Odd position: held character is longitude, the current one latitude.
    mhloc_pair_value u_pair_value (
        .i_lon_ch (r_held),
        .i_lat_ch (r_s1_ch),
        .i_pair   (r_position[POS_W-1:1]),
        .o_res    (pair_res)
    );

    always_comb begin
        n_position = r_position;
        n_held     = r_held;
        n_lon_sum  = r_lon_sum;
        n_lat_sum  = r_lat_sum;
        n_bad      = r_bad;
        in_window  = r_position < POS_W'(2 * MAX_PAIRS);

        // Drop characters past the last pair and an unpaired tail.
        if (in_window) begin
            n_position = r_position + POS_W'(1);
            if (!r_position[0]) begin
                n_held = r_s1_ch;
            end else if (pair_res.bad) begin
                n_bad = 1'b1;
            end else begin
                n_lon_sum = r_lon_sum + pair_res.lon_add;
                n_lat_sum = r_lat_sum + pair_res.lat_add;
            end
        end

        pairs  = n_position[POS_W-1:1];
        n_vres = (pairs != '0) && !n_bad;
        if (n_vres) begin
            n_lon = n_lon_sum[OUT_W-1:0] + center_offset(pairs);
            n_lat = n_lat_sum[OUT_W-1:0] + center_offset(pairs);
        end else begin
            n_lon = '0;
            n_lat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_position  <= '0;
            r_held      <= '0;
            r_lon_sum   <= '0;
            r_lat_sum   <= '0;
            r_bad       <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_in.valid;
            end

            // Clear the result on take; a new last character reloads it.
            if (s1_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // Return to the empty locator after every last character.
            if (s1_go) begin
                if (r_s1_last) begin
                    r_position <= '0;
                    r_held     <= '0;
                    r_lon_sum  <= '0;
                    r_lat_sum  <= '0;
                    r_bad      <= 1'b0;
                end else begin
                    r_position <= n_position;
                    r_held     <= n_held;
                    r_lon_sum  <= n_lon_sum;
                    r_lat_sum  <= n_lat_sum;
                    r_bad      <= n_bad;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_ch   <= i_in.ch;
            r_s1_last <= i_in.last;
        end
        if (s1_go && r_s1_last) begin
            r_lon  <= n_lon;
            r_lat  <= n_lat;
            r_vres <= n_vres;
        end
    end

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n,
        r_position <= POS_W'(2 * MAX_PAIRS), "position past last pair")
    `ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, s1_go && r_s1_last,
        r_out_valid && r_position == '0 && !r_bad && r_lon_sum == '0,
        "state not cleared after last character")
    `ASSERT_IMPLIES(a_invalid_zero, i_clk, i_rst_n, r_out_valid && !r_vres,
        r_lon == '0 && r_lat == '0, "invalid result with nonzero position")

endmodule
